// File: src/b64sc_pkg.sv
// Shared types, constants and character mapping for the base64 stream codec.
package b64sc_pkg;

	localparam int unsigned QueueDepthDefault = 2;
	localparam int unsigned MaxResults = 4;

	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	localparam logic [7:0] PAD_CHAR = 8'h3D;

	// One item's worth of results, handed from front to back.
	typedef struct packed {
		logic [2:0]      cnt;
		logic [3:0][7:0] chars;
		logic            has;
		logic            last;
	} cmd_t;

	// 6-bit value to standard alphabet character.
	function automatic logic [7:0] enc_char(input logic [5:0] v);
		logic [7:0] c;
		begin
			if (v < 6'd26) begin
				c = 8'h41 + {2'b00, v};
			end else if (v < 6'd52) begin
				c = 8'h61 + {2'b00, v - 6'd26};
			end else if (v < 6'd62) begin
				c = 8'h30 + {2'b00, v - 6'd52};
			end else if (v == 6'd62) begin
				c = 8'h2B;
			end else begin
				c = 8'h2F;
			end
			return c;
		end
	endfunction

	// Character to {valid, 6-bit value}.
	function automatic logic [6:0] dec_char(input logic [7:0] c);
		logic [6:0] r;
		begin
			if (c >= 8'h41 && c <= 8'h5A) begin
				r = {1'b1, 6'(c - 8'h41)};
			end else if (c >= 8'h61 && c <= 8'h7A) begin
				r = {1'b1, 6'(c - 8'h61 + 8'd26)};
			end else if (c >= 8'h30 && c <= 8'h39) begin
				r = {1'b1, 6'(c - 8'h30 + 8'd52)};
			end else if (c == 8'h2B) begin
				r = {1'b1, 6'd62};
			end else if (c == 8'h2F) begin
				r = {1'b1, 6'd63};
			end else begin
				r = 7'd0;
			end
			return r;
		end
	endfunction

endpackage

// File: src/b64sc_front.sv
// Front end: accepts items, updates the bit stream state and builds result commands.
module b64sc_front
	import b64sc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_mode,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	input  logic       q_full,
	output logic       push,
	output cmd_t       cmd
);

	logic        mode_q;
	logic [11:0] acc_q;
	logic [3:0]  pend_q;
	logic [1:0]  chars_q;
	logic        pad_q;

	logic [11:0] acc;
	logic [4:0]  p;
	logic [1:0]  chars_n;
	logic        pad;
	logic [2:0]  n;
	logic [11:0] sh;
	logic [6:0]  dv;
	logic        take;

	assign cfg_ready = 1'b1;
	assign in_ready  = !q_full;
	assign take      = in_valid && in_ready;

	always_comb begin
		acc     = acc_q;
		p       = {1'b0, pend_q};
		chars_n = chars_q;
		pad     = pad_q;
		n       = 3'd0;
		sh      = '0;
		dv      = dec_char(in_byte);
		cmd     = '0;
		cmd.has = 1'b1;
		cmd.last = in_last;
		if (mode_q == MODE_ENCODE) begin
			acc = {acc_q[3:0], in_byte};
			p   = p + 5'd8;
			for (int k = 0; k < 2; k++) begin
				if (p >= 5'd6 && p <= 5'd12) begin
					sh = acc >> (p - 5'd6);
					if (n < 3'd4) begin
						cmd.chars[n[1:0]] = enc_char(sh[5:0]);
						n = n + 3'd1;
					end
					chars_n = chars_n + 2'd1;
					p = p - 5'd6;
				end
			end
			if (in_last) begin
				if (p > 5'd0 && p < 5'd6) begin
					sh = acc << (5'd6 - p);
					if (n < 3'd4) begin
						cmd.chars[n[1:0]] = enc_char(sh[5:0]);
						n = n + 3'd1;
					end
					chars_n = chars_n + 2'd1;
				end
				for (int k = 0; k < 3; k++) begin
					if (chars_n != 2'd0 && n < 3'd4) begin
						cmd.chars[n[1:0]] = PAD_CHAR;
						n = n + 3'd1;
						chars_n = chars_n + 2'd1;
					end
				end
			end
		end else begin
			if (!pad_q) begin
				if (in_byte == PAD_CHAR) begin
					pad = 1'b1;
				end else if (dv[6]) begin
					acc = {acc_q[5:0], dv[5:0]};
					p   = p + 5'd6;
					if (p >= 5'd8 && p <= 5'd12) begin
						sh = acc >> (p - 5'd8);
						cmd.chars[0] = sh[7:0];
						n = 3'd1;
						p = p - 5'd8;
					end
				end
			end
			// bare end marker when the last item yields nothing
			if (in_last && n == 3'd0) begin
				cmd.has = 1'b0;
				n = 3'd1;
			end
		end
		cmd.cnt = n;
	end

	assign push = take && (n != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_ENCODE;
			acc_q   <= '0;
			pend_q  <= '0;
			chars_q <= '0;
			pad_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			mode_q  <= cfg_mode;
			acc_q   <= '0;
			pend_q  <= '0;
			chars_q <= '0;
			pad_q   <= 1'b0;
		end else if (take) begin
			if (in_last) begin
				acc_q   <= '0;
				pend_q  <= '0;
				chars_q <= '0;
				pad_q   <= 1'b0;
			end else begin
				acc_q   <= acc;
				pend_q  <= p[3:0];
				chars_q <= chars_n;
				pad_q   <= pad;
			end
		end
	end

endmodule

// File: src/b64sc_fifo.sv
// Short command queue between front and back.
module b64sc_fifo
	import b64sc_pkg::*;
#(
	parameter int unsigned Depth = QueueDepthDefault
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wdata,
	input  logic pop,
	output cmd_t rdata,
	output logic full,
	output logic nonempty
);

	localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CW = $clog2(Depth + 1);

	cmd_t          slots_q [Depth];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign full     = (cnt_q == CW'(Depth));
	assign nonempty = (cnt_q != '0);
	assign rdata    = slots_q[rd_q];

	function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] ptr);
		return (ptr == AW'(Depth - 1)) ? '0 : ptr + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= next_ptr(wr_q);
			end
			if (pop) begin
				rd_q <= next_ptr(rd_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: src/b64sc_back.sv
// Back end: walks the head command one result per cycle into the output register, unless the output stalls.
module b64sc_back
	import b64sc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       head,
	input  logic       head_valid,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       has_data,
	output logic       out_last
);

	logic [1:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       has_q;
	logic       last_q;
	logic       load;
	logic       final_res;

	assign load      = head_valid && (!valid_q || out_ready);
	assign final_res = ({1'b0, idx_q} == (head.cnt - 3'd1));
	assign pop       = load && final_res;

	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign has_data  = has_q;
	assign out_last  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= final_res ? 2'd0 : idx_q + 2'd1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= head.chars[idx_q];
			has_q  <= head.has;
			last_q <= head.last && final_res;
		end
	end

endmodule

// File: src/base64_stream_codec.sv
// Top level of the streaming base64 encoder / decoder.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------
//  cfg      | cfg_valid / cfg_ready | cfg_mode (0 encode, 1 decode)
//  in       | in_valid / in_ready   | in_byte, in_last
//  out      | out_valid / out_ready | out_byte, has_data, out_last
//
// The front takes one item per cycle while the command queue has room; the back
// drains one result per cycle while the output register is free or being taken. An
// item yields one or two results per encoded byte, up to four on the last byte, at
// most one per decoded character.
// The output register sets the pace; a stalled output fills the queue, then drops in_ready.
// Reset clears mode to encode and all stream state; cfg_ready is always high.
module base64_stream_codec
	import b64sc_pkg::*;
#(
	parameter int unsigned QueueDepth = QueueDepthDefault
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_mode,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       has_data,
	output logic       out_last
);

	cmd_t cmd;
	cmd_t head;
	logic push;
	logic pop;
	logic q_full;
	logic q_nonempty;

	b64sc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_mode  (cfg_mode),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.q_full    (q_full),
		.push      (push),
		.cmd       (cmd)
	);

	b64sc_fifo #(
		.Depth (QueueDepth)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wdata    (cmd),
		.pop      (pop),
		.rdata    (head),
		.full     (q_full),
		.nonempty (q_nonempty)
	);

	b64sc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (q_nonempty),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.has_data   (has_data),
		.out_last   (out_last)
	);

endmodule

// File: dv/b64sc_checker.sv
// Checker for the base64 stream codec: predicts each result and compares it on the out channel.
module b64sc_checker
	import b64sc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic       cfg_mode,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] out_byte,
	input  logic       has_data,
	input  logic       out_last,
	output int         errors,
	output int         outstanding
);

	typedef struct packed {
		logic [7:0] data;
		logic       has;
		logic       last;
	} codec_result_t;

	logic          mode;
	logic [11:0]   acc;
	logic [3:0]    nbits;
	logic [1:0]    nchars;
	logic          pad_seen;
	codec_result_t step_buf [4];
	int            step_cnt;
	codec_result_t awaited_results [$];

	function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
		if (v < 6'd26) return 8'("A" + v);
		if (v < 6'd52) return 8'("a" + (v - 6'd26));
		if (v < 6'd62) return 8'("0" + (v - 6'd52));
		if (v == 6'd62) return "+";
		return "/";
	endfunction

	// -1 for anything outside the alphabet
	function automatic int char_to_sextet(input logic [7:0] c);
		if (c >= "A" && c <= "Z") return int'(c - "A");
		if (c >= "a" && c <= "z") return int'(c - "a") + 26;
		if (c >= "0" && c <= "9") return int'(c - "0") + 52;
		if (c == "+") return 62;
		if (c == "/") return 63;
		return -1;
	endfunction

	task automatic clear_stream();
		acc = '0;
		nbits = '0;
		nchars = '0;
		pad_seen = 1'b0;
	endtask

	// At most four results per item; anything beyond is dropped.
	task automatic add_result(input logic [7:0] d, input logic h, input logic l);
		if (step_cnt < 4) begin
			step_buf[step_cnt] = '{data: d, has: h, last: l};
			step_cnt++;
		end
	endtask

	task automatic add_char(input logic [7:0] c);
		add_result(c, 1'b1, 1'b0);
		nchars = nchars + 2'd1;
	endtask

	task automatic codec_step(input logic [7:0] b, input logic l);
		int v;
		step_cnt = 0;
		if (mode == MODE_ENCODE) begin
			acc = {acc[3:0], b};
			nbits = nbits + 4'd8;
			while (nbits >= 4'd6 && nbits <= 4'd12) begin
				add_char(sextet_to_char(6'(acc >> (nbits - 4'd6))));
				nbits = nbits - 4'd6;
			end
			if (l) begin
				// flush leftover bits, zero-filled on the right, then pad to a full quad
				if (nbits > 4'd0 && nbits < 4'd6)
					add_char(sextet_to_char(6'(acc << (4'd6 - nbits))));
				while (nchars != 2'd0 && step_cnt < 4)
					add_char(PAD_CHAR);
				if (step_cnt > 0)
					step_buf[step_cnt - 1].last = 1'b1;
				clear_stream();
			end
		end else begin
			if (!pad_seen) begin
				if (b == PAD_CHAR) begin
					pad_seen = 1'b1;
				end else begin
					v = char_to_sextet(b);
					if (v >= 0) begin
						acc = {acc[5:0], 6'(v)};
						nbits = nbits + 4'd6;
						if (nbits >= 4'd8) begin
							add_result(8'(acc >> (nbits - 4'd8)), 1'b1, l);
							nbits = nbits - 4'd8;
						end
					end
				end
			end
			if (l) begin
				if (step_cnt == 0)
					add_result(8'h00, 1'b0, 1'b1);
				clear_stream();
			end
		end
		for (int i = 0; i < step_cnt; i++)
			awaited_results.push_back(step_buf[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		codec_result_t want;
		if (!arst_n) begin
			mode = MODE_ENCODE;
			clear_stream();
			awaited_results.delete();
			errors = 0;
		end else begin
			// a mode write also abandons any message in progress
			if (cfg_valid && cfg_ready) begin
				mode = cfg_mode;
				clear_stream();
			end
			if (in_valid && in_ready)
				codec_step(in_byte, in_last);
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					$error("unexpected result: out_byte %02h has_data %0b out_last %0b",
						out_byte, has_data, out_last);
					errors++;
				end else begin
					want = awaited_results.pop_front();
					if (out_byte !== want.data) begin
						$error("out_byte: expected %02h, got %02h", want.data, out_byte);
						errors++;
					end
					if (has_data !== want.has) begin
						$error("has_data: expected %0b, got %0b", want.has, has_data);
						errors++;
					end
					if (out_last !== want.last) begin
						$error("out_last: expected %0b, got %0b", want.last, out_last);
						errors++;
					end
				end
			end
		end
		outstanding = awaited_results.size();
	end

endmodule

// File: dv/tb_top.sv
// Top of the base64 stream codec testbench: clock, reset, stimulus, receiver and verdict.
module tb_top;
	import b64sc_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 16;
	localparam int HOLD_CYCLES = 60;
	localparam int RANDOM_ITEMS = 100;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic       cfg_mode = MODE_ENCODE;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] in_byte = 8'h00;
	logic       in_last = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic       has_data;
	logic       out_last;

	int    errors;
	int    outstanding;
	int    tx_gap_max = 7;
	int    rx_stall_max = 7;
	int    rx_hold_len = 0;
	int    quiet_cycles = 0;
	int    random_sent = 0;
	string b64_alpha = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	base64_stream_codec dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_mode (cfg_mode),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte (out_byte),
		.has_data (has_data),
		.out_last (out_last)
	);

	b64sc_checker codec_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_mode   (cfg_mode),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.in_last    (in_last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.has_data   (has_data),
		.out_last   (out_last),
		.errors     (errors),
		.outstanding(outstanding)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Receiver: random stall per result, or one long hold when asked.
	initial begin
		int stall;
		forever begin
			if (rx_hold_len > 0) begin
				stall = rx_hold_len;
				rx_hold_len = 0;
			end else begin
				stall = $urandom_range(rx_stall_max, 0);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// Hold valid and payload until accepted; valid stays up when there is no gap.
	task automatic send_item(input logic [7:0] b, input logic l);
		int gap;
		gap = $urandom_range(tx_gap_max, 0);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		in_last <= l;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], i == s.len() - 1);
	endtask

	task automatic send_queue(input logic [7:0] q [$]);
		for (int i = 0; i < q.size(); i++)
			send_item(q[i], i == q.size() - 1);
		random_sent += q.size();
	endtask

	// Drop valid, wait for all results, then let the block finish any silent item.
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input logic m);
		cfg_valid <= 1'b1;
		cfg_mode <= m;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_encode_msg();
		logic [7:0] q [$];
		int len;
		len = $urandom_range(8, 1);
		repeat (len) q.push_back(8'($urandom_range(255, 0)));
		send_queue(q);
	endtask

	// Mostly well-formed quads with optional padding and stray characters;
	// now and then a run of arbitrary bytes.
	task automatic random_decode_msg();
		logic [7:0] q [$];
		int quads;
		int npad;
		if ($urandom_range(9, 0) == 0) begin
			repeat ($urandom_range(8, 1)) q.push_back(8'($urandom_range(255, 0)));
		end else begin
			quads = $urandom_range(3, 1);
			npad = $urandom_range(2, 0);
			for (int i = 0; i < quads * 4; i++) begin
				if ($urandom_range(9, 0) == 0)
					q.push_back(8'($urandom_range(255, 0)));
				if (i >= quads * 4 - npad)
					q.push_back(PAD_CHAR);
				else
					q.push_back(b64_alpha[$urandom_range(63, 0)]);
			end
		end
		send_queue(q);
	endtask

	initial begin
		logic m;
		int phase;
		int phase_start;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// encode: one, two and three byte messages, extreme byte values
		write_mode(MODE_ENCODE);
		send_text("f");
		send_text("fo");
		send_item(8'hFF, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b1);
		settle();

		// decode: full quad, chars after pad, stray chars, dropped leftover bits,
		// bare end markers
		write_mode(MODE_DECODE);
		send_text("Zm9v");
		send_text("Zg=A");
		send_item("!", 1'b0);
		send_item(8'hFF, 1'b0);
		send_item("Q", 1'b0);
		send_item("Q", 1'b1);
		send_item(8'h00, 1'b1);
		send_item(PAD_CHAR, 1'b1);
		// abandon a message by rewriting the mode; the next char must start fresh
		send_item("Z", 1'b0);
		send_item("m", 1'b0);
		settle();
		write_mode(MODE_DECODE);
		send_item("Q", 1'b1);
		settle();
		write_mode(MODE_ENCODE);
		send_item(8'h00, 1'b0);
		send_item("/", 1'b1);
		settle();

		phase = 0;
		while (random_sent < RANDOM_ITEMS) begin
			m = (phase == 0) ? MODE_DECODE : logic'($urandom_range(1, 0));
			if (phase % 3 == 0) begin
				tx_gap_max = 0;
				rx_stall_max = 0;
			end else begin
				tx_gap_max = 7;
				rx_stall_max = 7;
			end
			settle();
			write_mode(m);
			phase_start = random_sent;
			while (random_sent - phase_start < 25) begin
				// stall the output long enough to back up the input
				if (phase == 1 && random_sent == phase_start)
					rx_hold_len = HOLD_CYCLES;
				if (m == MODE_ENCODE)
					random_encode_msg();
				else
					random_decode_msg();
				// pause the input until everything has drained
				if (phase == 2 && random_sent - phase_start < 10)
					settle();
			end
			phase++;
		end

		settle();
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
